/* sv/sogi_pll_phase_tracker_top_defines.svh */
// Assertion macros shared by the phase tracker RTL.
`ifndef SOGI_PLL_PHASE_TRACKER_TOP_DEFINES_SVH
`define SOGI_PLL_PHASE_TRACKER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define SOGI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define SOGI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/sogi_pkg.sv */
// Package with types, constants and the sine table of the phase tracker.
`default_nettype none
package sogi_pkg;

  localparam int SINE_ADDR_BITS = 10;
  localparam int SINE_WIDTH     = 16;
  localparam int QBITS          = SINE_ADDR_BITS - 2;
  localparam int QLEN           = 1 << QBITS;
  localparam int SINE_SH        = SINE_WIDTH - 1;

  localparam int MUL_A_W = 35;
  localparam int MUL_B_W = 25;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam longint unsigned Q30_ONE = 64'd1073741824;
  localparam longint unsigned PC1 = 64'd1686629713;
  localparam longint unsigned PC3 = 64'd693598667;
  localparam longint unsigned PC5 = 64'd85569303;
  localparam longint unsigned PC7 = 64'd5026996;
  localparam longint unsigned PC9 = 64'd172272;

  // Register indexes of the configuration port.
  localparam logic [2:0] CFG_SOGI_GAIN  = 3'd0;
  localparam logic [2:0] CFG_NOM_STEP   = 3'd1;
  localparam logic [2:0] CFG_CORR_LIMIT = 3'd2;
  localparam logic [2:0] CFG_KP_GAIN    = 3'd3;
  localparam logic [2:0] CFG_KI_GAIN    = 3'd4;

  // Product steps of one sample.
  localparam logic [2:0] STP_ERR_G   = 3'd0;
  localparam logic [2:0] STP_ALPHA_G = 3'd1;
  localparam logic [2:0] STP_C_BETA  = 3'd2;
  localparam logic [2:0] STP_S_ALPHA = 3'd3;
  localparam logic [2:0] STP_C_ALPHA = 3'd4;
  localparam logic [2:0] STP_S_BETA  = 3'd5;
  localparam logic [2:0] STP_DQ_KP   = 3'd6;
  localparam logic [2:0] STP_Q_KI    = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MULT,
    ST_ACC,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [23:0] sogi_gain;
    logic [31:0] nominal_step;
    logic [30:0] correction_limit;
    logic [19:0] kp_gain;
    logic [19:0] ki_gain;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] freq_correction;
    logic signed [13:0] quad_axis;
    logic signed [13:0] direct_axis;
    logic signed [13:0] quadrature;
    logic signed [13:0] in_phase;
    logic [15:0]        phase;
  } res_t;

  typedef logic [SINE_WIDTH-1:0] qtab_t [QLEN+1];

  // Quarter-wave sine magnitudes, index 0 to QLEN inclusive.
  function automatic qtab_t build_qtab();
    qtab_t tab;
    longint unsigned x, x2, t, amp, s;
    amp = (64'd1 << (SINE_WIDTH - 1)) - 64'd1;
    for (int i = 0; i <= QLEN; i++) begin
      x  = longint'(i) << (30 - QBITS);
      x2 = (x * x) >> 30;
      t  = PC9;
      t  = PC7 - ((x2 * t) >> 30);
      t  = PC5 - ((x2 * t) >> 30);
      t  = PC3 - ((x2 * t) >> 30);
      t  = PC1 - ((x2 * t) >> 30);
      t  = (x * t) >> 30;
      if (t > Q30_ONE) t = Q30_ONE;
      s = (t * amp + (64'd1 << 29)) >> 30;
      tab[i] = SINE_WIDTH'(s);
    end
    return tab;
  endfunction

  localparam qtab_t QTAB = build_qtab();

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Integer part of a Q16.16 value, saturated to 14 bits.
  function automatic logic signed [13:0] int14(input logic signed [31:0] v);
    logic signed [15:0] hi;
    hi = v[31:16];
    if (hi > 16'sd8191) return 14'sh1FFF;
    if (hi < -16'sd8192) return 14'sh2000;
    return hi[13:0];
  endfunction

endpackage
`default_nettype wire

/* sv/sogi_mul.sv */
// Shared signed multiplier with a registered product.
`default_nettype none
module sogi_mul import sogi_pkg::*; (
  input  wire logic                      clk_i,
  input  wire logic signed [MUL_A_W-1:0] a_i,
  input  wire logic signed [MUL_B_W-1:0] b_i,
  output logic signed [MUL_P_W-1:0]      prod_o
);

  logic signed [MUL_P_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= MUL_P_W'(a_i) * MUL_P_W'(b_i);
  end

  assign prod_o = prod_q;

endmodule
`default_nettype wire

/* sv/sogi_sine.sv */
// Sine and cosine lookup from the quarter-wave table, registered outputs.
`default_nettype none
module sogi_sine import sogi_pkg::*; (
  input  wire logic                         clk_i,
  input  wire logic [31:0]                  phase_i,
  output logic signed [SINE_WIDTH-1:0]      sin_o,
  output logic signed [SINE_WIDTH-1:0]      cos_o
);

  logic [SINE_ADDR_BITS-1:0] s_idx, c_idx;
  logic signed [SINE_WIDTH-1:0] sin_q, cos_q;

  function automatic logic signed [SINE_WIDTH-1:0] lookup(
      input logic [SINE_ADDR_BITS-1:0] idx);
    logic [1:0]       quad;
    logic [QBITS-1:0] r;
    logic [QBITS:0]   pos;
    logic signed [SINE_WIDTH-1:0] v;
    quad = idx[SINE_ADDR_BITS-1 -: 2];
    r    = idx[QBITS-1:0];
    pos  = quad[0] ? ((QBITS+1)'(QLEN) - {1'b0, r}) : {1'b0, r};
    v    = QTAB[pos];
    return quad[1] ? -v : v;
  endfunction

  assign s_idx = phase_i[31 -: SINE_ADDR_BITS];
  assign c_idx = s_idx + SINE_ADDR_BITS'(QLEN);

  always_ff @(posedge clk_i) begin
    sin_q <= lookup(s_idx);
    cos_q <= lookup(c_idx);
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule
`default_nettype wire

/* sv/sogi_core.sv */
// Sequencer and datapath: SOGI, Park rotation, PI loop and phase accumulator.
`default_nettype none
module sogi_core import sogi_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic signed [12:0] sample_i,
  input  wire cfg_t              cfg_i,
  input  wire logic              out_free_i,
  output logic                   idle_o,
  output logic                   done_o,
  output res_t                   res_o
);

  state_e state_q, state_d;
  logic [2:0] step_q, step_d;
  logic signed [12:0] x_q, x_d;
  logic signed [31:0] alpha_q, alpha_d, beta_q, beta_d, corr_q, corr_d;
  logic signed [31:0] prev_q, prev_d, vq_q, vq_d, vd_q, vd_d;
  logic [31:0] phase_q, phase_d, phase_nxt;
  logic signed [MUL_P_W-1:0] t_q, t_d, prod;
  logic signed [MUL_A_W-1:0] op_a_q, op_a_d;
  logic signed [MUL_B_W-1:0] op_b_q, op_b_d;
  logic signed [SINE_WIDTH-1:0] sin_v, cos_v;
  logic signed [MUL_A_W-1:0] err;
  logic signed [63:0] pi_sum, corr_w, lim;

  sogi_mul u_mul (.clk_i(clk_i), .a_i(op_a_q), .b_i(op_b_q), .prod_o(prod));
  sogi_sine u_sine (.clk_i(clk_i), .phase_i(phase_q), .sin_o(sin_v), .cos_o(cos_v));

  assign err = {{(MUL_A_W-29){x_q[12]}}, x_q, 16'd0} - MUL_A_W'(alpha_q)
               - MUL_A_W'(beta_q);
  assign pi_sum = 64'(t_q) + 64'(prod);
  assign corr_w = 64'(corr_q) + (pi_sum >>> 16);
  assign lim = 64'({1'b0, cfg_i.correction_limit});
  assign phase_nxt = phase_q + cfg_i.nominal_step + corr_q;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    x_d = x_q; alpha_d = alpha_q; beta_d = beta_q; corr_d = corr_q;
    prev_d = prev_q; vq_d = vq_q; vd_d = vd_q; phase_d = phase_q; t_d = t_q;
    op_a_d = op_a_q; op_b_d = op_b_q;
    done_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          x_d = sample_i;
          step_d = STP_ERR_G;
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_d = ST_MULT;
        case (step_q)
          STP_ERR_G:   begin op_a_d = err; op_b_d = MUL_B_W'(cfg_i.sogi_gain); end
          STP_ALPHA_G: begin op_a_d = MUL_A_W'(alpha_q); op_b_d = MUL_B_W'(cfg_i.sogi_gain); end
          STP_C_BETA:  begin op_a_d = MUL_A_W'(beta_q);  op_b_d = MUL_B_W'(cos_v); end
          STP_S_ALPHA: begin op_a_d = MUL_A_W'(alpha_q); op_b_d = MUL_B_W'(sin_v); end
          STP_C_ALPHA: begin op_a_d = MUL_A_W'(alpha_q); op_b_d = MUL_B_W'(cos_v); end
          STP_S_BETA:  begin op_a_d = MUL_A_W'(beta_q);  op_b_d = MUL_B_W'(sin_v); end
          STP_DQ_KP: begin
            op_a_d = MUL_A_W'(vq_q) - MUL_A_W'(prev_q);
            op_b_d = MUL_B_W'(cfg_i.kp_gain);
          end
          default: begin op_a_d = MUL_A_W'(vq_q); op_b_d = MUL_B_W'(cfg_i.ki_gain); end
        endcase
      end
      ST_MULT: state_d = ST_ACC;
      ST_ACC: begin
        state_d = ST_LOAD;
        step_d = step_q + 3'd1;
        case (step_q)
          STP_ERR_G:   alpha_d = sat32(64'(alpha_q) + 64'(prod >>> 24));
          STP_ALPHA_G: beta_d  = sat32(64'(beta_q) + 64'(prod >>> 24));
          STP_C_BETA:  t_d = prod;
          STP_S_ALPHA: vq_d = sat32(64'((t_q - prod) >>> SINE_SH));
          STP_C_ALPHA: t_d = prod;
          STP_S_BETA:  vd_d = sat32(64'((t_q + prod) >>> SINE_SH));
          STP_DQ_KP:   t_d = prod;
          default: begin
            // Clamp the integrated correction to the symmetric limit.
            if (corr_w > lim) corr_d = lim[31:0];
            else if (corr_w < -lim) corr_d = 32'(-lim);
            else corr_d = corr_w[31:0];
            prev_d = vq_q;
            state_d = ST_OUT;
          end
        endcase
      end
      ST_OUT: begin
        if (out_free_i) begin
          done_o = 1'b1;
          phase_d = phase_nxt;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= STP_ERR_G;
      alpha_q <= '0; beta_q <= '0; corr_q <= '0; prev_q <= '0; phase_q <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      alpha_q <= alpha_d; beta_q <= beta_d; corr_q <= corr_d;
      prev_q  <= prev_d; phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; vq_q <= vq_d; vd_q <= vd_d; t_q <= t_d;
    op_a_q <= op_a_d; op_b_q <= op_b_d;
  end

  assign idle_o = (state_q == ST_IDLE);
  assign res_o.phase           = phase_nxt[31:16];
  assign res_o.in_phase        = int14(alpha_q);
  assign res_o.quadrature      = int14(beta_q);
  assign res_o.direct_axis     = int14(vd_q);
  assign res_o.quad_axis       = int14(vq_q);
  assign res_o.freq_correction = corr_q;

endmodule
`default_nettype wire

/* sv/sogi_pll_phase_tracker_top.sv */
// Top level of the SOGI PLL phase tracker: ports, configuration and output register.
//
// Usage: each transfer on the slave stream carries one signed 13-bit ADC sample
// in s_axis_tdata[12:0]. The block runs it through the SOGI filter, the Park
// rotation and the PI loop, advances its phase accumulator and presents one
// result transfer on the master stream with phase, alpha, beta, vD, vQ and the
// frequency correction. All products go through a single shared multiplier
// stepped by a small sequencer: each of the eight products passes through a
// load, a multiply and an accumulate state, and an output state then hands
// the result over. The block takes no new sample until it has returned to
// idle after handing over the result.
// s_axis_tready is low while a sample is being worked on.
// The result sits in an output register; if the receiver stalls, the block
// finishes the next sample and then waits until that register is free.
// Configuration writes are always ready and take effect at once; write them
// only while the block is idle. Writes to indexes beyond the register list
// are ignored. Reset loads the default gains and clears all filter, loop and
// phase state, and empties the output register.
`default_nettype none
`include "sogi_pll_phase_tracker_top_defines.svh"
module sogi_pll_phase_tracker_top import sogi_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [15:0]  s_axis_tdata,   // [12:0] sample, rest zero
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [15:0] phase, [29:16] in_phase, [43:30] quadrature, [57:44] direct_axis,
  // [71:58] quad_axis, [103:72] freq_correction
  output logic [103:0]      m_axis_tdata,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [2:0]   cfg_index_i,
  input  wire logic [31:0]  cfg_data_i
);

  cfg_t cfg_q, cfg_d;
  res_t res, out_q;
  logic out_vld_q;
  logic core_idle, core_done, out_free;

  assign cfg_ready_o = 1'b1;

  // Register file; an index outside the list leaves every register as it is.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SOGI_GAIN:  cfg_d.sogi_gain        = cfg_data_i[23:0];
        CFG_NOM_STEP:   cfg_d.nominal_step     = cfg_data_i;
        CFG_CORR_LIMIT: cfg_d.correction_limit = cfg_data_i[30:0];
        CFG_KP_GAIN:    cfg_d.kp_gain          = cfg_data_i[19:0];
        CFG_KI_GAIN:    cfg_d.ki_gain          = cfg_data_i[19:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sogi_gain        <= 24'd105414;
      cfg_q.nominal_step     <= 32'd4294967;
      cfg_q.correction_limit <= 31'd858993;
      cfg_q.kp_gain          <= 20'd95697;
      cfg_q.ki_gain          <= 20'd13671;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // The core may hand over a result when the output register is empty or
  // being emptied in this cycle.
  assign out_free = !out_vld_q || m_axis_tready;

  sogi_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (s_axis_tvalid && s_axis_tready),
    .sample_i   (s_axis_tdata[12:0]),
    .cfg_i      (cfg_q),
    .out_free_i (out_free),
    .idle_o     (core_idle),
    .done_o     (core_done),
    .res_o      (res)
  );

  assign s_axis_tready = core_idle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (core_done) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_done) out_q <= res;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  `SOGI_ASSERT_NXT(a_busy_after_take, s_axis_tvalid && s_axis_tready, !s_axis_tready,
                   "block accepted a sample while still busy")
  `SOGI_ASSERT_IMP(a_no_overwrite, core_done, !out_vld_q || m_axis_tready,
                   "result handed over while output register full")
  `SOGI_ASSERT_IMP(a_corr_limit, m_axis_tvalid,
                   ($signed(out_q.freq_correction) <= $signed({1'b0, cfg_q.correction_limit})) &&
                   ($signed(out_q.freq_correction) >= -$signed({1'b0, cfg_q.correction_limit})),
                   "frequency correction outside its limit")

endmodule
`default_nettype wire
